// ===== rtl/core/pgsd_pkg.sv =====
// Shared types, constants and Gold sequence helper functions for the PDSCH scrambler.
// Used by pgsd_cfg_regs, pgsd_gold_gen and the top level under rtl/core; depends on nothing else.
package pgsd_pkg;

	localparam int GOLD_W    = 31;
	localparam int GOLD_JUMP = 1600;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 3;

	typedef logic [GOLD_W-1:0] gold_t;
	typedef logic [GOLD_W-1:0][GOLD_W-1:0] gold_cols_t;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DIRECTION     = 3'd0,
		CFG_MBSFN_MODE    = 3'd1,
		CFG_RNTI          = 3'd2,
		CFG_CODEWORD      = 3'd3,
		CFG_SLOT_NUMBER   = 3'd4,
		CFG_CELL_ID       = 3'd5,
		CFG_MBSFN_AREA_ID = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic        direction;
		logic        mbsfn_mode;
		logic [15:0] rnti;
		logic        codeword;
		logic [4:0]  slot_number;
		logic [8:0]  cell_id;
		logic [7:0]  mbsfn_area_id;
	} cfg_t;

	// One step of x1: x1(n+31) = x1(n+3) ^ x1(n).
	function automatic gold_t x1_step(input gold_t x);
		return {x[0] ^ x[3], x[GOLD_W-1:1]};
	endfunction

	// One step of x2: x2(n+31) = x2(n+3) ^ x2(n+2) ^ x2(n+1) ^ x2(n).
	function automatic gold_t x2_step(input gold_t x);
		return {x[0] ^ x[1] ^ x[2] ^ x[3], x[GOLD_W-1:1]};
	endfunction

	// x1 after the jump from the fixed start value of one; evaluated at elaboration.
	function automatic gold_t x1_jump_value();
		gold_t v;
		v = gold_t'(1);
		for (int n = 0; n < GOLD_JUMP; n++) begin
			v = x1_step(v);
		end
		return v;
	endfunction

	// Column j holds x2 after the jump when started from the unit vector j.
	// The jump is linear, so the jumped x2 is the XOR of columns picked by c_init.
	function automatic gold_cols_t x2_jump_cols();
		gold_cols_t cols;
		gold_t      v;
		for (int j = 0; j < GOLD_W; j++) begin
			v = gold_t'(1) << j;
			for (int n = 0; n < GOLD_JUMP; n++) begin
				v = x2_step(v);
			end
			cols[j] = v;
		end
		return cols;
	endfunction

	localparam gold_t      X1_JUMP  = x1_jump_value();
	localparam gold_cols_t X2_JCOLS = x2_jump_cols();

endpackage

// ===== rtl/core/pgsd_cfg_regs.sv =====
// Configuration register file of the PDSCH scrambler, written through a plain write port.
// Depends on pgsd_pkg.
module pgsd_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [pgsd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pgsd_pkg::CFG_W-1:0]     cfg_data,
	output pgsd_pkg::cfg_t                 cfg
);

	pgsd_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr_en) begin
			case (pgsd_pkg::cfg_idx_t'(cfg_index))
				pgsd_pkg::CFG_DIRECTION:     cfg_q.direction     <= cfg_data[0];
				pgsd_pkg::CFG_MBSFN_MODE:    cfg_q.mbsfn_mode    <= cfg_data[0];
				pgsd_pkg::CFG_RNTI:          cfg_q.rnti          <= cfg_data[15:0];
				pgsd_pkg::CFG_CODEWORD:      cfg_q.codeword      <= cfg_data[0];
				pgsd_pkg::CFG_SLOT_NUMBER:   cfg_q.slot_number   <= cfg_data[4:0];
				pgsd_pkg::CFG_CELL_ID:       cfg_q.cell_id       <= cfg_data[8:0];
				pgsd_pkg::CFG_MBSFN_AREA_ID: cfg_q.mbsfn_area_id <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/core/pgsd_gold_gen.sv =====
// Gold sequence generator: holds x1 and x2, restarts from c_init with the 1600-step jump
// folded into constant column tables, and steps once per processed item. Depends on pgsd_pkg.
module pgsd_gold_gen (
	input  logic           clk,
	input  logic           arst_n,
	input  pgsd_pkg::cfg_t cfg,
	input  logic           step,
	input  logic           first,
	output logic           c
);

	pgsd_pkg::gold_t x1_q, x2_q;
	pgsd_pkg::gold_t cinit, x2_jump, cur_x1, cur_x2;

	// The fields of c_init do not overlap, so the sums are plain concatenations.
	always_comb begin
		if (cfg.mbsfn_mode) begin
			cinit = {18'd0, cfg.slot_number[4:1], 1'b0, cfg.mbsfn_area_id};
		end else begin
			cinit = {1'b0, cfg.rnti, cfg.codeword, cfg.slot_number[4:1], cfg.cell_id};
		end
	end

	always_comb begin
		x2_jump = '0;
		for (int j = 0; j < pgsd_pkg::GOLD_W; j++) begin
			if (cinit[j]) begin
				x2_jump = x2_jump ^ pgsd_pkg::X2_JCOLS[j];
			end
		end
	end

	assign cur_x1 = first ? pgsd_pkg::X1_JUMP : x1_q;
	assign cur_x2 = first ? x2_jump : x2_q;
	assign c      = cur_x1[0] ^ cur_x2[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x1_q <= '0;
			x2_q <= '0;
		end else if (step) begin
			x1_q <= pgsd_pkg::x1_step(cur_x1);
			x2_q <= pgsd_pkg::x2_step(cur_x2);
		end
	end

endmodule

// ===== rtl/core/pgsd_sample_map.sv =====
// Applies one Gold bit to a sample: XOR on the hard bit when scrambling, sign flip with
// saturation on the LLR when descrambling. Depends on no other file.
module pgsd_sample_map #(
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic                           direction,
	input  logic                           c,
	input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
	output logic signed [SAMPLE_WIDTH-1:0] sample_out
);

	localparam logic [SAMPLE_WIDTH-1:0] MOST_NEG = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
	localparam logic [SAMPLE_WIDTH-1:0] MOST_POS = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};

	always_comb begin
		if (!direction) begin
			sample_out = '0;
			sample_out[0] = sample_in[0] ^ c;
		end else if (c) begin
			sample_out = sample_in;
		end else if (sample_in == MOST_NEG) begin
			// The most negative value has no positive counterpart.
			sample_out = MOST_POS;
		end else begin
			sample_out = -sample_in;
		end
	end

endmodule

// ===== rtl/core/pdsch_gold_scrambler_descrambler.sv =====
// Top level of the PDSCH Gold sequence scrambler and descrambler.
// Depends on pgsd_pkg, pgsd_cfg_regs, pgsd_gold_gen and pgsd_sample_map.
//
//  channel   | direction | handshake              | contents
//  s_axis    | in        | tvalid/tready          | tdata: sample_in; tlast: last_in; tuser: first
//  m_axis    | out       | tvalid/tready          | tdata: sample_out; tlast: last_out
//  cfg       | in        | cfg_wr_en, no wait     | cfg_index selects register, cfg_data value
//
// One item per cycle is sustained while m_axis_tready stays high. Each item passes the input
// register, then the result register, before it is valid on m_axis. A restart does not
// stall the flow because the 1600-step jump is a constant linear map. Reset clears the
// valid flags, the configuration and both sequence registers. A stall on m_axis holds the
// result register; one more item waits in the input register.
module pdsch_gold_scrambler_descrambler #(
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [pgsd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pgsd_pkg::CFG_W-1:0]     cfg_data,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// tdata fields from bit 0: sample_in, then zero fill to whole bytes.
	input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
	input  logic                           s_axis_tlast,
	// tuser fields from bit 0: first.
	input  logic                           s_axis_tuser,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// tdata fields from bit 0: sample_out, then zero fill to whole bytes.
	output logic [((SAMPLE_WIDTH+7)/8)*8-1:0] m_axis_tdata,
	output logic                           m_axis_tlast
);

	pgsd_pkg::cfg_t cfg;
	logic valid_s1, first_s1, last_s1;
	logic signed [SAMPLE_WIDTH-1:0] sample_s1;
	logic valid_s2, last_s2;
	logic signed [SAMPLE_WIDTH-1:0] sample_s2;
	logic signed [SAMPLE_WIDTH-1:0] mapped;
	logic adv_s1, c;

	pgsd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign adv_s1        = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv_s1;

	pgsd_gold_gen u_gold (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.step   (adv_s1),
		.first  (first_s1),
		.c      (c)
	);

	pgsd_sample_map #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_map (
		.direction  (cfg.direction),
		.c          (c),
		.sample_in  (sample_s1),
		.sample_out (mapped)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
			end else if (m_axis_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			first_s1  <= s_axis_tuser;
			last_s1   <= s_axis_tlast;
			sample_s1 <= s_axis_tdata[SAMPLE_WIDTH-1:0];
		end
		if (adv_s1) begin
			last_s2   <= last_s1;
			sample_s2 <= mapped;
		end
	end

	always_comb begin
		m_axis_tdata = '0;
		m_axis_tdata[SAMPLE_WIDTH-1:0] = sample_s2;
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tlast  = last_s2;

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the PDSCH Gold sequence scrambler and descrambler.
// Needs pgsd_pkg and the RTL top level; a scoreboard class predicts every result.
module testbench;

	localparam int SAMPLE_WIDTH  = 16;
	localparam int TDATA_W       = ((SAMPLE_WIDTH + 7) / 8) * 8;
	localparam int CFG_DW        = pgsd_pkg::CFG_W;
	localparam int CFG_IW        = pgsd_pkg::CFG_IDX_W;
	localparam int PHASE_COUNT   = 8;
	localparam int PHASE_ITEMS   = 215;
	localparam int HOLD_CYCLES   = 250;
	localparam int HOLD_AFTER    = 300;
	localparam int CYCLE_LIMIT   = 1000000;

	typedef logic [SAMPLE_WIDTH-1:0] sample_t;

	typedef struct packed {
		sample_t sample;
		logic    last;
	} llr_result_t;

	class gold_scoreboard;
		bit          direction;
		bit          mbsfn_mode;
		bit [15:0]   rnti;
		bit          codeword;
		bit [4:0]    slot_number;
		bit [8:0]    cell_id;
		bit [7:0]    mbsfn_area_id;
		bit [30:0]   x1;
		bit [30:0]   x2;
		llr_result_t due_results[$];
		int          accepted;
		int          errors;

		function void set_reg(pgsd_pkg::cfg_idx_t idx, logic [CFG_DW-1:0] value);
			case (idx)
				pgsd_pkg::CFG_DIRECTION:     direction = value[0];
				pgsd_pkg::CFG_MBSFN_MODE:    mbsfn_mode = value[0];
				pgsd_pkg::CFG_RNTI:          rnti = value[15:0];
				pgsd_pkg::CFG_CODEWORD:      codeword = value[0];
				pgsd_pkg::CFG_SLOT_NUMBER:   slot_number = value[4:0];
				pgsd_pkg::CFG_CELL_ID:       cell_id = value[8:0];
				pgsd_pkg::CFG_MBSFN_AREA_ID: mbsfn_area_id = value[7:0];
				default: ;
			endcase
		endfunction

		function void advance_gold();
			x1 = {x1[0] ^ x1[3], x1[30:1]};
			x2 = {x2[0] ^ x2[1] ^ x2[2] ^ x2[3], x2[30:1]};
		endfunction

		function void restart_gold();
			int unsigned seed_value;
			if (mbsfn_mode)
				seed_value = ((slot_number >> 1) << 9) + mbsfn_area_id;
			else
				seed_value = (int'(rnti) << 14) + (int'(codeword) << 13)
					+ ((slot_number >> 1) << 9) + cell_id;
			x1 = 31'd1;
			x2 = seed_value[30:0];
			repeat (pgsd_pkg::GOLD_JUMP) advance_gold();
		endfunction

		function sample_t map_sample(sample_t raw, bit c);
			if (!direction)
				return sample_t'(raw[0] ^ c);
			if (c)
				return raw;
			// Negating the most negative value saturates.
			if (raw == {1'b1, {(SAMPLE_WIDTH-1){1'b0}}})
				return {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
			return -raw;
		endfunction

		function void take_input(bit is_first, bit is_last, sample_t raw);
			llr_result_t r;
			if (is_first)
				restart_gold();
			r.sample = map_sample(raw, x1[0] ^ x2[0]);
			r.last = is_last;
			due_results.push_back(r);
			advance_gold();
			accepted++;
		endfunction

		task report(string msg);
			$display("[%0t] mismatch: %s", $time, msg);
			errors++;
		endtask

		task check_output(sample_t sample, logic last);
			llr_result_t want;
			if (due_results.size() == 0) begin
				report($sformatf("result %h with nothing pending", sample));
			end else begin
				want = due_results.pop_front();
				if (sample !== want.sample)
					report($sformatf("sample_out %h, wanted %h", sample, want.sample));
				if (last !== want.last)
					report($sformatf("last_out %b, wanted %b", last, want.last));
			end
		endtask
	endclass

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_wr_en;
	logic [CFG_IW-1:0]       cfg_index;
	logic [CFG_DW-1:0]       cfg_data;
	logic                    s_axis_tvalid;
	logic                    s_axis_tready;
	logic [TDATA_W-1:0]      s_axis_tdata;
	logic                    s_axis_tlast;
	logic                    s_axis_tuser;
	logic                    m_axis_tvalid;
	logic                    m_axis_tready;
	logic [TDATA_W-1:0]      m_axis_tdata;
	logic                    m_axis_tlast;

	gold_scoreboard model = new();
	bit             full_rate;
	int             cycle_count;

	pdsch_gold_scrambler_descrambler #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Mostly back to back, sometimes a short gap, rarely a long one.
	function automatic int pick_gap();
		int r;
		if (full_rate)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_item(input bit is_first, input bit is_last, input sample_t raw);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= TDATA_W'(raw);
		s_axis_tlast <= is_last;
		s_axis_tuser <= is_first;
		do @(posedge clk); while (!s_axis_tready);
		model.take_input(is_first, is_last, raw);
	endtask

	task automatic stop_input();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
	endtask

	// Registers change only with the pipeline drained.
	task automatic settle();
		while (model.due_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input pgsd_pkg::cfg_idx_t idx, input logic [CFG_DW-1:0] value);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		model.set_reg(idx, value);
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic configure(input bit dir, input bit mbsfn, input logic [15:0] rnti_v,
			input bit cw, input logic [4:0] slot, input logic [8:0] cell_v,
			input logic [7:0] area);
		settle();
		write_reg(pgsd_pkg::CFG_DIRECTION, CFG_DW'(dir));
		write_reg(pgsd_pkg::CFG_MBSFN_MODE, CFG_DW'(mbsfn));
		write_reg(pgsd_pkg::CFG_RNTI, CFG_DW'(rnti_v));
		write_reg(pgsd_pkg::CFG_CODEWORD, CFG_DW'(cw));
		write_reg(pgsd_pkg::CFG_SLOT_NUMBER, CFG_DW'(slot));
		write_reg(pgsd_pkg::CFG_CELL_ID, CFG_DW'(cell_v));
		write_reg(pgsd_pkg::CFG_MBSFN_AREA_ID, CFG_DW'(area));
	endtask

	function automatic sample_t pick_sample();
		case ($urandom_range(0, 19))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'hFFFF;
			3: return 16'h0000;
			default: return sample_t'($urandom);
		endcase
	endfunction

	// Codewords of random length; a few start without a restart or carry stray marks.
	task automatic run_codewords(input int item_count);
		int  sent;
		int  len;
		bit  f;
		bit  l;
		bit  no_restart;
		sent = 0;
		while (sent < item_count) begin
			len = ($urandom_range(0, 4) != 0) ? $urandom_range(1, 40) : $urandom_range(41, 150);
			no_restart = ($urandom_range(0, 9) == 0);
			for (int k = 0; k < len && sent < item_count; k++) begin
				f = (k == 0) && !no_restart;
				l = (k == len - 1);
				if ($urandom_range(0, 19) == 0)
					f = 1'($urandom_range(0, 1));
				if ($urandom_range(0, 19) == 0)
					l = 1'($urandom_range(0, 1));
				send_item(f, l, pick_sample());
				sent++;
			end
		end
		stop_input();
	endtask

	// Output side: random bursts and stalls, plus one long hold-off to back up the input.
	initial begin
		int  run;
		int  stall;
		bit  held_off;
		held_off = 1'b0;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (full_rate) begin
				@(negedge clk);
				m_axis_tready <= 1'b1;
			end else if (!held_off && model.accepted >= HOLD_AFTER) begin
				@(negedge clk);
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				held_off = 1'b1;
			end else begin
				run = $urandom_range(1, 24);
				@(negedge clk);
				m_axis_tready <= 1'b1;
				repeat (run - 1) @(negedge clk);
				stall = pick_gap();
				if (stall > 0) begin
					@(negedge clk);
					m_axis_tready <= 1'b0;
					repeat (stall - 1) @(negedge clk);
				end
			end
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready)
				model.check_output(sample_t'(m_axis_tdata), m_axis_tlast);
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAILURE");
		$finish;
	end

	initial begin
		bit          dir;
		bit          mbsfn;
		logic [4:0]  slot;
		logic [8:0]  cell_v;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tlast = 1'b0;
		s_axis_tuser = 1'b0;
		full_rate = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Without a restart the sequence registers stay zero, so c is zero.
		send_item(1'b0, 1'b0, 16'h0000);
		send_item(1'b0, 1'b0, 16'h0001);
		send_item(1'b0, 1'b0, 16'hFFFE);
		send_item(1'b0, 1'b1, 16'hFFFF);
		stop_input();
		settle();
		write_reg(pgsd_pkg::CFG_DIRECTION, CFG_DW'(1));
		send_item(1'b0, 1'b0, 16'h8000);
		send_item(1'b0, 1'b0, 16'h7FFF);
		send_item(1'b0, 1'b0, 16'h0000);
		send_item(1'b0, 1'b0, 16'hFFFF);
		send_item(1'b0, 1'b1, 16'h0001);
		// Restart with every identity at zero.
		send_item(1'b1, 1'b0, 16'h8000);
		send_item(1'b0, 1'b0, 16'h7FFF);
		send_item(1'b0, 1'b0, 16'h8000);
		send_item(1'b0, 1'b0, 16'h1234);
		send_item(1'b0, 1'b1, 16'h8000);
		stop_input();
		// Every identity at its widest value, slot and cell beyond their legal range.
		configure(1'b1, 1'b0, 16'hFFFF, 1'b1, 5'd31, 9'd511, 8'd255);
		send_item(1'b1, 1'b0, 16'hFFFF);
		send_item(1'b0, 1'b0, 16'h8000);
		send_item(1'b0, 1'b0, 16'h7FFF);
		send_item(1'b0, 1'b1, 16'h0000);
		stop_input();
		configure(1'b1, 1'b1, 16'hFFFF, 1'b1, 5'd31, 9'd511, 8'd255);
		send_item(1'b1, 1'b0, 16'h8000);
		send_item(1'b0, 1'b0, 16'h5555);
		send_item(1'b0, 1'b1, 16'hAAAA);
		stop_input();
		configure(1'b0, 1'b1, 16'hFFFF, 1'b1, 5'd31, 9'd511, 8'd255);
		send_item(1'b1, 1'b0, 16'h0001);
		send_item(1'b0, 1'b0, 16'hFFFE);
		send_item(1'b0, 1'b0, 16'h7FFF);
		send_item(1'b0, 1'b1, 16'h8000);
		stop_input();

		for (int ph = 0; ph < PHASE_COUNT; ph++) begin
			if (ph == 0) begin
				configure(1'b1, 1'b0, 16'h0000, 1'b0, 5'd0, 9'd0, 8'd0);
			end else if (ph == 1) begin
				configure(1'b0, 1'b0, 16'hFFFF, 1'b1, 5'd19, 9'd503, 8'd255);
			end else begin
				dir = 1'($urandom_range(0, 1));
				mbsfn = ($urandom_range(0, 2) == 0);
				slot = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(20, 31))
					: 5'($urandom_range(0, 19));
				cell_v = ($urandom_range(0, 3) == 0) ? 9'($urandom_range(504, 511))
					: 9'($urandom_range(0, 503));
				configure(dir, mbsfn, 16'($urandom), 1'($urandom_range(0, 1)), slot, cell_v,
					8'($urandom));
			end
			full_rate = (ph == 3);
			run_codewords(PHASE_ITEMS);
		end
		full_rate = 1'b0;

		while (model.due_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (model.errors == 0 && model.due_results.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/pgsd_pkg.sv
rtl/core/pgsd_cfg_regs.sv
rtl/core/pgsd_gold_gen.sv
rtl/core/pgsd_sample_map.sv
rtl/core/pdsch_gold_scrambler_descrambler.sv
sim/testbench.sv
